// ===== sv/protobuf_envelope_stream_parser_macros.svh =====
// assertion macros shared by the envelope parser modules
`ifndef PROTOBUF_ENVELOPE_STREAM_PARSER_MACROS_SVH
`define PROTOBUF_ENVELOPE_STREAM_PARSER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define PESP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// next-cycle implication, disabled during reset
`define PESP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define PESP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PESP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/pesp_pkg.sv =====
// types, codes and constants of the envelope stream parser
`default_nettype none

package pesp_pkg;

    // message limits and check values
    localparam logic [31:0] MAX_MESSAGE_BYTES = 32'd1048576;
    localparam int          LEN_W             = 21;
    localparam logic [LEN_W-1:0] DIGEST_BYTES = 21'd32;
    localparam logic [3:0]  VARINT_LAST_IDX   = 4'd9;
    localparam int          FIFO_DEPTH        = 4;
    localparam int          FIFO_PTR_W        = 2;
    localparam int          FIFO_CNT_W        = 3;

    // wire types
    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_LEN    = 3'd2;

    // configuration register indexes
    localparam logic [0:0] CFG_EXP_MAJOR = 1'b0;
    localparam logic [0:0] CFG_EXP_MINOR = 1'b1;

    typedef enum logic [2:0] {
        KIND_VARINT   = 3'd0,
        KIND_DATA     = 3'd1,
        KIND_EMPTY    = 3'd2,
        KIND_ACCEPTED = 3'd3,
        KIND_ERROR    = 3'd4
    } t_kind;

    typedef enum logic [3:0] {
        ERR_NONE          = 4'd0,
        ERR_TRUNC_VARINT  = 4'd1,
        ERR_VARINT_LONG   = 4'd2,
        ERR_TRUNC_LENGTH  = 4'd3,
        ERR_WIRE_TYPE     = 4'd4,
        ERR_UNKNOWN_FIELD = 4'd5,
        ERR_OVERFLOW      = 4'd6,
        ERR_DIGEST_LENGTH = 4'd7,
        ERR_SCHEMA        = 4'd8
    } t_err;

    typedef enum logic [4:0] {
        PH_TAG    = 5'b00001,
        PH_VALUE  = 5'b00010,
        PH_LENGTH = 5'b00100,
        PH_DATA   = 5'b01000,
        PH_DRAIN  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_item;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [2:0]  field_number;
        logic [31:0] field_value;
        logic        field_done;
        logic [3:0]  error_code;
        logic        final_result;
    } t_result;

    // result write strobes from the parser to the queue
    typedef struct packed {
        logic v0;
        logic v1;
    } t_push;

    function automatic t_result mk_result(t_kind kind, logic [2:0] field,
                                          logic [31:0] value, logic done,
                                          t_err code, logic fin);
        t_result r;
        r.result_kind  = kind;
        r.field_number = field;
        r.field_value  = value;
        r.field_done   = done;
        r.error_code   = code;
        r.final_result = fin;
        return r;
    endfunction

    function automatic t_result mk_error(t_err code);
        return mk_result(KIND_ERROR, 3'd0, 32'd0, 1'b0, code, 1'b1);
    endfunction

endpackage

`default_nettype wire

// ===== sv/protobuf_envelope_stream_parser.sv =====
// top level of the envelope stream parser: input register, parser, result queue
`default_nettype none

// Takes one message byte per transfer with an end-of-message mark and returns
// field values, data bytes tagged with their field, and one final accepted or
// error result per message. A byte is taken every cycle while the receiver keeps
// up. The parse step runs only when the four-entry result queue has two free
// slots. A byte with two results always closes a message that opened with a tag
// byte without results, so a receiver that takes a result every cycle never lets
// the queue pass that bound. The input stalls only while results back up behind
// a stalled receiver. A byte's first result passes through the input register
// and the result queue before it is offered. A second result of the same byte
// follows once the first has gone.
// expected_major and expected_minor are to be written through the config port
// only while no message is in flight; the block itself does not enforce this.

module protobuf_envelope_stream_parser
    import pesp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_item       i_item,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_result          o_result,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_wr_data
);

    logic        r_in_valid, n_in_valid;
    t_item       r_in_item;
    logic [31:0] r_exp_major;
    logic [31:0] r_exp_minor;
    logic        fire;
    logic        accept;
    logic        room;
    t_push       push;
    t_result     res0, res1;

    // input register: advance when the queue has room for two results
    assign fire    = r_in_valid && room;
    assign o_stall = r_in_valid && !room;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept)
            n_in_valid = 1'b1;
        else if (fire)
            n_in_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_in_valid <= 1'b0;
        else
            r_in_valid <= n_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (accept)
            r_in_item <= i_item;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_major <= 32'd0;
            r_exp_minor <= 32'd1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_EXP_MAJOR: r_exp_major <= i_cfg_wr_data;
                CFG_EXP_MINOR: r_exp_minor <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    pesp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_in_item),
        .i_exp_major (r_exp_major),
        .i_exp_minor (r_exp_minor),
        .o_push      (push),
        .o_res0      (res0),
        .o_res1      (res1)
    );

    pesp_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_res0   (res0),
        .i_res1   (res1),
        .o_room   (room),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

// ===== sv/pesp_parser.sv =====
// per-byte parse step: varint assembly, field rules and end-of-message checks
`default_nettype none
`include "protobuf_envelope_stream_parser_macros.svh"

module pesp_parser
    import pesp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_fire,
    input  wire t_item       i_item,
    input  wire logic [31:0] i_exp_major,
    input  wire logic [31:0] i_exp_minor,
    output t_push            o_push,
    output t_result          o_res0,
    output t_result          o_res1
);

    t_phase          r_phase, n_phase;
    logic [31:0]     r_acc_lo, n_acc_lo;
    logic            r_acc_hi, n_acc_hi;
    logic [3:0]      r_vcnt, n_vcnt;
    logic [2:0]      r_field, n_field;
    logic [LEN_W-1:0] r_remain, n_remain;
    logic [31:0]     r_seen_major, n_seen_major;
    logic [31:0]     r_seen_minor, n_seen_minor;
    logic [LEN_W-1:0] r_digest_len, n_digest_len;

    logic [7:0]  b;
    logic        eom;
    logic [6:0]  chunk;
    logic [31:0] lo_add;
    logic        hi_add;
    logic [31:0] v_lo;
    logic        v_hi;
    logic [2:0]  fno;
    logic        fno_ok;
    logic        wt_ok;
    logic        too_big;
    logic        v_zero;
    logic        data_done;
    logic        do_clear;
    logic        do_drain;
    t_push       push;
    t_result     res0, res1;

    assign b     = i_item.data_byte;
    assign eom   = i_item.end_of_message;
    assign chunk = b[6:0];

    // place the 7 payload bits at their varint position; bits past 63 fall off
    always_comb begin
        lo_add = 32'd0;
        hi_add = 1'b0;
        case (r_vcnt) inside
            4'd0: lo_add = {25'd0, chunk};
            4'd1: lo_add = {18'd0, chunk, 7'd0};
            4'd2: lo_add = {11'd0, chunk, 14'd0};
            4'd3: lo_add = {4'd0, chunk, 21'd0};
            4'd4: begin
                lo_add = {chunk[3:0], 28'd0};
                hi_add = |chunk[6:4];
            end
            [4'd5:4'd8]: hi_add = |chunk;
            default: hi_add = chunk[0];
        endcase
    end

    // completed varint value and the checks made on it
    assign v_lo      = r_acc_lo | lo_add;
    assign v_hi      = r_acc_hi | hi_add;
    assign fno       = v_lo[5:3];
    assign fno_ok    = !v_hi && (v_lo[31:6] == 26'd0) && (fno != 3'd0);
    assign wt_ok     = (fno <= 3'd2) ? (v_lo[2:0] == WT_VARINT) : (v_lo[2:0] == WT_LEN);
    assign too_big   = v_hi || (v_lo > MAX_MESSAGE_BYTES);
    assign v_zero    = !v_hi && (v_lo == 32'd0);
    assign data_done = r_remain <= 21'd1;

    function automatic t_result finish(logic [LEN_W-1:0] dlen, logic [31:0] maj,
                                       logic [31:0] mnr, logic [31:0] exp_maj,
                                       logic [31:0] exp_mnr);
        if (dlen != DIGEST_BYTES)
            return mk_error(ERR_DIGEST_LENGTH);
        else if (maj != exp_maj || mnr != exp_mnr)
            return mk_error(ERR_SCHEMA);
        else
            return mk_result(KIND_ACCEPTED, 3'd0, 32'd0, 1'b0, ERR_NONE, 1'b1);
    endfunction

    // one parse step for the transfer in the input register
    always_comb begin
        n_phase      = r_phase;
        n_acc_lo     = r_acc_lo;
        n_acc_hi     = r_acc_hi;
        n_vcnt       = r_vcnt;
        n_field      = r_field;
        n_remain     = r_remain;
        n_seen_major = r_seen_major;
        n_seen_minor = r_seen_minor;
        n_digest_len = r_digest_len;
        push         = '0;
        res0         = '0;
        res1         = '0;
        do_clear     = 1'b0;
        do_drain     = 1'b0;
        if (i_fire) begin
            case (r_phase)
                PH_DRAIN: begin
                    do_clear = eom;
                end
                PH_DATA: begin
                    push.v0 = 1'b1;
                    res0 = mk_result(KIND_DATA, r_field, {24'd0, b}, data_done,
                                     ERR_NONE, 1'b0);
                    if (r_remain != '0)
                        n_remain = r_remain - 21'd1;
                    if (data_done) begin
                        n_phase = PH_TAG;
                        if (eom) begin
                            push.v1  = 1'b1;
                            res1     = finish(r_digest_len, r_seen_major, r_seen_minor,
                                              i_exp_major, i_exp_minor);
                            do_clear = 1'b1;
                        end
                    end else if (eom) begin
                        push.v1  = 1'b1;
                        res1     = mk_error(ERR_TRUNC_LENGTH);
                        do_clear = 1'b1;
                    end
                end
                PH_TAG, PH_VALUE, PH_LENGTH: begin
                    if (b[7]) begin
                        // continuation byte
                        if (r_vcnt == VARINT_LAST_IDX) begin
                            push.v0  = 1'b1;
                            res0     = mk_error(ERR_VARINT_LONG);
                            do_clear = eom;
                            do_drain = !eom;
                        end else begin
                            n_acc_lo = v_lo;
                            n_acc_hi = v_hi;
                            n_vcnt   = r_vcnt + 4'd1;
                            if (eom) begin
                                push.v0  = 1'b1;
                                res0     = mk_error(ERR_TRUNC_VARINT);
                                do_clear = 1'b1;
                            end
                        end
                    end else begin
                        // varint complete
                        n_acc_lo = 32'd0;
                        n_acc_hi = 1'b0;
                        n_vcnt   = 4'd0;
                        case (r_phase)
                            PH_TAG: begin
                                if (!fno_ok || !wt_ok || eom) begin
                                    push.v0 = 1'b1;
                                    if (!fno_ok)
                                        res0 = mk_error(ERR_UNKNOWN_FIELD);
                                    else if (!wt_ok)
                                        res0 = mk_error(ERR_WIRE_TYPE);
                                    else
                                        res0 = mk_error(ERR_TRUNC_VARINT);
                                    do_clear = eom;
                                    do_drain = !eom;
                                end else begin
                                    n_field = fno;
                                    n_phase = (fno <= 3'd2) ? PH_VALUE : PH_LENGTH;
                                end
                            end
                            PH_VALUE: begin
                                push.v0 = 1'b1;
                                if (v_hi) begin
                                    res0     = mk_error(ERR_OVERFLOW);
                                    do_clear = eom;
                                    do_drain = !eom;
                                end else begin
                                    if (r_field == 3'd1)
                                        n_seen_major = v_lo;
                                    else
                                        n_seen_minor = v_lo;
                                    res0 = mk_result(KIND_VARINT, r_field, v_lo, 1'b0,
                                                     ERR_NONE, 1'b0);
                                    n_phase = PH_TAG;
                                    if (eom) begin
                                        push.v1  = 1'b1;
                                        res1     = finish(n_digest_len, n_seen_major,
                                                          n_seen_minor, i_exp_major,
                                                          i_exp_minor);
                                        do_clear = 1'b1;
                                    end
                                end
                            end
                            default: begin
                                // length of a length-delimited field
                                if (too_big || (eom && !v_zero)) begin
                                    push.v0  = 1'b1;
                                    res0     = mk_error(ERR_TRUNC_LENGTH);
                                    do_clear = eom;
                                    do_drain = !eom;
                                end else begin
                                    if (r_field == 3'd7)
                                        n_digest_len = v_lo[LEN_W-1:0];
                                    if (v_zero) begin
                                        push.v0 = 1'b1;
                                        res0    = mk_result(KIND_EMPTY, r_field, 32'd0,
                                                            1'b1, ERR_NONE, 1'b0);
                                        n_phase = PH_TAG;
                                        if (eom) begin
                                            push.v1  = 1'b1;
                                            res1     = finish(n_digest_len, n_seen_major,
                                                              n_seen_minor, i_exp_major,
                                                              i_exp_minor);
                                            do_clear = 1'b1;
                                        end
                                    end else begin
                                        n_remain = v_lo[LEN_W-1:0];
                                        n_phase  = PH_DATA;
                                    end
                                end
                            end
                        endcase
                    end
                end
                default: begin
                    do_clear = 1'b1;
                end
            endcase
        end
        // error without end mark: drop bytes until the end mark
        if (do_drain) begin
            n_phase  = PH_DRAIN;
            n_acc_lo = 32'd0;
            n_acc_hi = 1'b0;
            n_vcnt   = 4'd0;
        end
        // end of message: back to the reset state
        if (do_clear) begin
            n_phase      = PH_TAG;
            n_acc_lo     = 32'd0;
            n_acc_hi     = 1'b0;
            n_vcnt       = 4'd0;
            n_field      = 3'd0;
            n_remain     = '0;
            n_seen_major = 32'd0;
            n_seen_minor = 32'd0;
            n_digest_len = '0;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_TAG;
            r_acc_lo     <= 32'd0;
            r_acc_hi     <= 1'b0;
            r_vcnt       <= 4'd0;
            r_field      <= 3'd0;
            r_remain     <= '0;
            r_seen_major <= 32'd0;
            r_seen_minor <= 32'd0;
            r_digest_len <= '0;
        end else begin
            r_phase      <= n_phase;
            r_acc_lo     <= n_acc_lo;
            r_acc_hi     <= n_acc_hi;
            r_vcnt       <= n_vcnt;
            r_field      <= n_field;
            r_remain     <= n_remain;
            r_seen_major <= n_seen_major;
            r_seen_minor <= n_seen_minor;
            r_digest_len <= n_digest_len;
        end
    end

    assign o_push = push;
    assign o_res0 = res0;
    assign o_res1 = res1;

    // a second result only follows a first one that does not close the message
    `PESP_ASSERT_IMPLY(a_second_needs_first, i_clk, i_rst_n, push.v1, push.v0 && !res0.final_result)
    // the end mark always returns the parser to tag parsing
    `PESP_ASSERT_NEXT(a_eom_resets_phase, i_clk, i_rst_n, i_fire && eom, r_phase == PH_TAG)
    // a varint in progress is never left in the data or drain phases
    `PESP_ASSERT_IMPLY(a_no_stale_varint, i_clk, i_rst_n, (r_phase == PH_DATA) || (r_phase == PH_DRAIN), r_vcnt == 4'd0)

endmodule

`default_nettype wire

// ===== sv/pesp_result_fifo.sv =====
// four-entry result queue taking up to two results per cycle
`default_nettype none
`include "protobuf_envelope_stream_parser_macros.svh"

module pesp_result_fifo
    import pesp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_push   i_push,
    input  wire t_result i_res0,
    input  wire t_result i_res1,
    output logic         o_room,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_result      o_result
);

    t_result                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT_W-1:0]  r_count, n_count;
    logic                   pop;

    assign o_valid  = r_count != '0;
    assign pop      = o_valid && !i_stall;
    assign o_room   = r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign o_result = r_mem[r_rd_ptr];

    // pointer and fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_PTR_W'(i_push.v0) + FIFO_PTR_W'(i_push.v1);
        n_rd_ptr = r_rd_ptr + FIFO_PTR_W'(pop);
        n_count  = r_count + FIFO_CNT_W'(i_push.v0) + FIFO_CNT_W'(i_push.v1)
                 - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_push.v0)
            r_mem[r_wr_ptr] <= i_res0;
        if (i_push.v1)
            r_mem[r_wr_ptr + FIFO_PTR_W'(1)] <= i_res1;
    end

    // the queue never holds more than its depth
    `PESP_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FIFO_CNT_W'(FIFO_DEPTH))
    // two writes only arrive when two slots are free
    `PESP_ASSERT_IMPLY(a_push_fits, i_clk, i_rst_n, i_push.v1, o_room)

endmodule

`default_nettype wire
